>>> hdl/psq_pkg.sv
`default_nettype none

package psq_pkg;

    // Width of the kept-point counter and of the reported index.
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_MS   = 3'd4;

    typedef enum logic [1:0] {
        MODE_TIME   = 2'd0,
        MODE_DIST   = 2'd1,
        MODE_POINTS = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Item kinds carried on the input tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Default parameter values.
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_TIME_BITS  = 32;

    // Register values after reset.
    localparam int RST_WINDOW_MS    = 2000;
    localparam int RST_MIN_DISTANCE = 20;
    localparam int RST_MAX_POINTS   = 20;
    localparam int RST_MIN_GAP_MS   = 100;

endpackage

`default_nettype wire

>>> hdl/psq_slice.sv
`default_nettype none

module psq_slice #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             up_valid,
    output logic                  up_ready,
    input  wire logic [WIDTH-1:0] up_data,
    output logic                  dn_valid,
    input  wire logic             dn_ready,
    output logic [WIDTH-1:0]      dn_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // The stage takes a new word whenever it is empty or its word leaves this cycle.
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= up_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/psq_cfg.sv
`default_nettype none

module psq_cfg
    import psq_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TIME_BITS  = DEF_TIME_BITS,
    parameter int CFG_W      = TIME_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output mode_t                     capture_mode,
    output logic [TIME_BITS-1:0]      window_ms,
    output logic [COORD_BITS:0]       min_distance,
    output logic [COUNT_W-1:0]        max_points,
    output logic [TIME_BITS-1:0]      min_gap_ms,
    output logic                      mode_write
);

    mode_t                 mode_reg;
    logic [TIME_BITS-1:0]  window_reg;
    logic [COORD_BITS:0]   min_dist_reg;
    logic [COUNT_W-1:0]    max_pts_reg;
    logic [TIME_BITS-1:0]  gap_reg;
    logic                  wr_en;

    assign cfg_ready  = 1'b1;
    assign wr_en      = cfg_valid && cfg_ready;
    // A mode write also clears the captured points.
    assign mode_write = wr_en && (cfg_index == REG_CAPTURE_MODE);

    assign capture_mode = mode_reg;
    assign window_ms    = window_reg;
    assign min_distance = min_dist_reg;
    assign max_points   = max_pts_reg;
    assign min_gap_ms   = gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_POINTS;
            window_reg   <= TIME_BITS'(RST_WINDOW_MS);
            min_dist_reg <= (COORD_BITS + 1)'(RST_MIN_DISTANCE);
            max_pts_reg  <= COUNT_W'(RST_MAX_POINTS);
            gap_reg      <= TIME_BITS'(RST_MIN_GAP_MS);
        end
        else if (wr_en)
        begin
            unique case (cfg_index)
                REG_CAPTURE_MODE: mode_reg     <= mode_t'(cfg_data[1:0]);
                REG_WINDOW_MS:    window_reg   <= cfg_data[TIME_BITS-1:0];
                REG_MIN_DISTANCE: min_dist_reg <= cfg_data[COORD_BITS:0];
                REG_MAX_POINTS:   max_pts_reg  <= cfg_data[COUNT_W-1:0];
                REG_MIN_GAP_MS:   gap_reg      <= cfg_data[TIME_BITS-1:0];
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/psq_core.sv
`default_nettype none

module psq_core
    import psq_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Item from the input register.
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire logic                  opcode,
    input  wire logic [COORD_BITS-1:0] pos_x,
    input  wire logic [COORD_BITS-1:0] pos_y,
    input  wire logic                  button_down,
    input  wire logic [TIME_BITS-1:0]  stamp_ms,
    // Configuration.
    input  wire mode_t                 capture_mode,
    input  wire logic [TIME_BITS-1:0]  window_ms,
    input  wire logic [COORD_BITS:0]   min_distance,
    input  wire logic [COUNT_W-1:0]    max_points,
    input  wire logic [TIME_BITS-1:0]  min_gap_ms,
    input  wire logic                  mode_write,
    // Result toward the output register.
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output logic                       accepted,
    output logic [COORD_BITS-1:0]      kept_x,
    output logic [COORD_BITS-1:0]      kept_y,
    output logic [TIME_BITS-1:0]       kept_ms,
    output logic [COUNT_W-1:0]         point_index
);

    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [TIME_BITS-1:0]  first_ms_reg;
    logic [COORD_BITS-1:0] last_x_reg;
    logic [COORD_BITS-1:0] last_y_reg;
    logic [TIME_BITS-1:0]  last_ms_reg;

    logic                  advance;
    logic                  is_clear;
    logic                  count_zero;
    logic                  keep;
    logic [TIME_BITS-1:0]  since_first;
    logic [TIME_BITS-1:0]  since_last;
    logic [COORD_BITS:0]   diff_x;
    logic [COORD_BITS:0]   diff_y;
    logic [COORD_BITS-1:0] abs_x;
    logic [COORD_BITS-1:0] abs_y;
    logic [COORD_BITS:0]   manhattan;

    assign advance    = item_valid && res_ready;
    assign item_ready = res_ready;
    assign res_valid  = item_valid;
    assign is_clear   = (opcode == OP_CLEAR);
    assign count_zero = (count_reg == '0);

    // Elapsed times wrap with the free-running timestamp.
    assign since_first = stamp_ms - first_ms_reg;
    assign since_last  = stamp_ms - last_ms_reg;

    // Differences of two signed coordinates need one extra bit; their
    // magnitudes fit back into the coordinate width.
    assign diff_x    = {pos_x[COORD_BITS-1], pos_x} - {last_x_reg[COORD_BITS-1], last_x_reg};
    assign diff_y    = {pos_y[COORD_BITS-1], pos_y} - {last_y_reg[COORD_BITS-1], last_y_reg};
    assign abs_x     = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign abs_y     = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    assign manhattan = {1'b0, abs_x} + {1'b0, abs_y};

    always_comb
    begin
        keep = 1'b0;
        if (!is_clear)
        begin
            unique case (capture_mode)
                MODE_TIME:   keep = count_zero || (since_first < window_ms);
                MODE_DIST:   keep = count_zero || (manhattan > min_distance);
                MODE_POINTS: keep = button_down && (count_reg < max_points)
                                    && (count_zero || (since_last > min_gap_ms));
                MODE_NONE:   keep = 1'b0;
                default:     keep = 1'b0;
            endcase
        end
    end

    // A result that is not a kept point carries zeros.
    assign accepted    = keep;
    assign kept_x      = keep ? pos_x : '0;
    assign kept_y      = keep ? pos_y : '0;
    assign kept_ms     = keep ? stamp_ms : '0;
    assign point_index = keep ? count_reg : '0;

    always_comb
    begin
        count_next = count_reg;
        priority if (mode_write)
        begin
            count_next = '0;
        end
        else if (advance && is_clear)
        begin
            count_next = '0;
        end
        else if (advance && keep && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Last-point state is only read while the count is non-zero.
    always_ff @(posedge clk)
    begin
        if (advance && keep)
        begin
            if (count_zero)
            begin
                first_ms_reg <= stamp_ms;
            end
            last_x_reg  <= pos_x;
            last_y_reg  <= pos_y;
            last_ms_reg <= stamp_ms;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_clear) |=> (count_reg == '0))
        else $error("count not zero after a clear item");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && keep && !mode_write && (count_reg != COUNT_MAX))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not step after a kept point");

    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && !mode_write) |=> $stable(count_reg))
        else $error("count moved without an item or mode write");

    a_none_keeps_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (capture_mode == MODE_NONE) |-> !keep)
        else $error("point kept with capture disabled");

    a_points_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (capture_mode == MODE_POINTS && keep) |-> (count_reg < max_points))
        else $error("point mode kept past its limit");
`endif

endmodule

`default_nettype wire

>>> hdl/pointer_sample_qualifier.sv
`default_nettype none

// Pointer sample qualifier. Each input word is either a timestamped pointer
// sample (tuser = 0) or a clear of the captured points (tuser = 1); each input
// word gives exactly one output word, whose tuser bit says whether the sample
// was kept as a captured point, together with its position, time and index
// since the last clear (all zero when nothing was kept). The block takes one
// word per clock cycle while the output is not stalled. A word waits in the
// input register, where one pass of subtract-and-compare logic judges it
// against the registered last-point state; the edge that loads its result
// into the result register also updates that state, so back-to-back samples
// always see the previous decision. Output backpressure stalls the input only
// when both registers are full. Configuration is written through its own
// valid/ready channel, which is always ready; writing the capture mode also
// clears the captured points, and registers should be written only while no
// words are in flight.
module pointer_sample_qualifier
    import psq_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int TIME_BITS  = DEF_TIME_BITS,
    localparam int IN_BITS  = 2 * COORD_BITS + 1 + TIME_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 2 * COORD_BITS + TIME_BITS + COUNT_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
    localparam int CFG_W    = (TIME_BITS > COORD_BITS + 1) ? TIME_BITS : COORD_BITS + 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input words.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // pos_x, pos_y, button_down, stamp_ms, zero padding (from bit 0 up)
    input  wire logic [IN_W-1:0]        s_tdata,
    // opcode
    input  wire logic                   s_tuser,
    // Result words.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // kept_x, kept_y, kept_ms, point_index, zero padding (from bit 0 up)
    output logic [OUT_W-1:0]            m_tdata,
    // accepted
    output logic                        m_tuser,
    // Configuration writes.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int X_LO  = 0;
    localparam int Y_LO  = COORD_BITS;
    localparam int BT_LO = 2 * COORD_BITS;
    localparam int MS_LO = 2 * COORD_BITS + 1;

    logic                  item_valid;
    logic                  item_ready;
    logic [IN_BITS:0]      item_word;
    logic                  res_valid;
    logic                  res_ready;
    logic [OUT_BITS:0]     res_word;
    logic [OUT_BITS:0]     out_word;

    mode_t                 capture_mode;
    logic [TIME_BITS-1:0]  window_ms;
    logic [COORD_BITS:0]   min_distance;
    logic [COUNT_W-1:0]    max_points;
    logic [TIME_BITS-1:0]  min_gap_ms;
    logic                  mode_write;

    logic                  accepted;
    logic [COORD_BITS-1:0] kept_x;
    logic [COORD_BITS-1:0] kept_y;
    logic [TIME_BITS-1:0]  kept_ms;
    logic [COUNT_W-1:0]    point_index;

    psq_cfg #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS),
        .CFG_W      (CFG_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .capture_mode (capture_mode),
        .window_ms    (window_ms),
        .min_distance (min_distance),
        .max_points   (max_points),
        .min_gap_ms   (min_gap_ms),
        .mode_write   (mode_write)
    );

    // Input register: the opcode rides above the sample fields.
    psq_slice #(
        .WIDTH (IN_BITS + 1)
    ) u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_tvalid),
        .up_ready (s_tready),
        .up_data  ({s_tuser, s_tdata[IN_BITS-1:0]}),
        .dn_valid (item_valid),
        .dn_ready (item_ready),
        .dn_data  (item_word)
    );

    psq_core #(
        .COORD_BITS (COORD_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (item_word[IN_BITS]),
        .pos_x        (item_word[X_LO +: COORD_BITS]),
        .pos_y        (item_word[Y_LO +: COORD_BITS]),
        .button_down  (item_word[BT_LO]),
        .stamp_ms     (item_word[MS_LO +: TIME_BITS]),
        .capture_mode (capture_mode),
        .window_ms    (window_ms),
        .min_distance (min_distance),
        .max_points   (max_points),
        .min_gap_ms   (min_gap_ms),
        .mode_write   (mode_write),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .accepted     (accepted),
        .kept_x       (kept_x),
        .kept_y       (kept_y),
        .kept_ms      (kept_ms),
        .point_index  (point_index)
    );

    assign res_word = {accepted, point_index, kept_ms, kept_y, kept_x};

    // Result register: the accepted flag rides above the point fields.
    psq_slice #(
        .WIDTH (OUT_BITS + 1)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (res_valid),
        .up_ready (res_ready),
        .up_data  (res_word),
        .dn_valid (m_tvalid),
        .dn_ready (m_tready),
        .dn_data  (out_word)
    );

    assign m_tuser = out_word[OUT_BITS];
    assign m_tdata = OUT_W'(out_word[OUT_BITS-1:0]);

endmodule

`default_nettype wire

>>> verif/tb_pointer_sample_qualifier.sv
`default_nettype none

module tb_pointer_sample_qualifier;
    import psq_pkg::*;

    // Port widths. The input word carries pos_x, pos_y, button_down and stamp_ms
    // (65 bits, padded to 72), and the result word carries kept_x, kept_y, kept_ms
    // and point_index (80 bits). The widest register is 32 bits.
    localparam int IN_W  = 72;
    localparam int OUT_W = 80;
    localparam int CFG_W = 32;

    // Register indexes past the last register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Cycles with no handshake at all before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic               op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               btn;
        logic [31:0]        ms;
    } ptr_word_t;

    typedef struct packed {
        logic               kept;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        ms;
        logic [15:0]        idx;
    } point_rec_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    pointer_sample_qualifier i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Words waiting to be offered, and the results that accepted words must give,
    // oldest first.
    ptr_word_t  sample_queue[$];
    point_rec_t expected_points[$];

    // Handshakes seen at the last rising edge, for the processes that act on the
    // falling edge.
    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;

    // Idle rates in percent, and the length of a receiver hold-off still to run.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    int mismatches = 0;

    // Predictor state: a private copy of the registers and of the last-point
    // registers of the block.
    mode_t              pm_mode;
    logic [31:0]        pm_window;
    logic [16:0]        pm_min_dist;
    logic [15:0]        pm_max_points;
    logic [31:0]        pm_min_gap;
    logic [15:0]        pm_count;
    logic [31:0]        pm_first_ms;
    logic signed [15:0] pm_last_x;
    logic signed [15:0] pm_last_y;
    logic [31:0]        pm_last_ms;

    // Where the well-formed random traffic currently is: pointer time and position.
    logic [31:0]        gen_ms = '0;
    logic signed [15:0] gen_x = '0;
    logic signed [15:0] gen_y = '0;

    // Decides whether one word is kept and advances the predictor state. A clear
    // or a sample that is dropped gives an all-zero result.
    function automatic point_rec_t qualify_sample(input ptr_word_t w);
        point_rec_t  r;
        logic        keep;
        logic [31:0] since_first;
        logic [31:0] since_last;
        int          dx;
        int          dy;
        r = '0;
        keep = 1'b0;
        // Elapsed times wrap at 32 bits like the free-running stamp.
        since_first = w.ms - pm_first_ms;
        since_last  = w.ms - pm_last_ms;
        dx = int'(w.x) - int'(pm_last_x);
        dy = int'(w.y) - int'(pm_last_y);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        if (w.op == OP_CLEAR)
        begin
            pm_count = '0;
            return r;
        end
        case (pm_mode)
            MODE_TIME:
                keep = (pm_count == 0) || (since_first < pm_window);
            MODE_DIST:
                keep = (pm_count == 0) || (dx + dy > int'(pm_min_dist));
            MODE_POINTS:
                keep = w.btn && (pm_count < pm_max_points) &&
                       ((pm_count == 0) || (since_last > pm_min_gap));
            default:
                keep = 1'b0;
        endcase
        if (keep)
        begin
            if (pm_count == 0)
                pm_first_ms = w.ms;
            pm_last_x  = w.x;
            pm_last_y  = w.y;
            pm_last_ms = w.ms;
            r.kept = 1'b1;
            r.x    = w.x;
            r.y    = w.y;
            r.ms   = w.ms;
            r.idx  = pm_count;
            // The counter sticks at its maximum; later points repeat that index.
            if (pm_count != COUNT_MAX)
                pm_count = pm_count + 1'b1;
        end
        return r;
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor and predictor. Everything is sampled at the rising edge, so the
    // values seen are the ones in force before the edge.
    always @(posedge clk)
    begin
        point_rec_t want;
        point_rec_t got;
        ptr_word_t  taken;
        in_fire  <= s_tvalid && s_tready;
        cfg_fire <= cfg_valid && cfg_ready;
        if (!rst_n)
        begin
            pm_mode       = MODE_POINTS;
            pm_window     = RST_WINDOW_MS;
            pm_min_dist   = 17'(RST_MIN_DISTANCE);
            pm_max_points = 16'(RST_MAX_POINTS);
            pm_min_gap    = RST_MIN_GAP_MS;
            pm_count      = '0;
            pm_first_ms   = '0;
            pm_last_x     = '0;
            pm_last_y     = '0;
            pm_last_ms    = '0;
        end
        else
        begin
            // A result word leaves only after its input word has passed through the
            // input and result registers, so popping before pushing in the same edge is safe.
            if (m_tvalid && m_tready)
            begin
                got.kept = m_tuser;
                got.x    = m_tdata[15:0];
                got.y    = m_tdata[31:16];
                got.ms   = m_tdata[63:32];
                got.idx  = m_tdata[79:64];
                if (expected_points.size() == 0)
                begin
                    $display("%0t: no result expected, got %h %h", $time, m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    report_field("accepted", want.kept, got.kept);
                    report_field("kept_x", want.x, got.x);
                    report_field("kept_y", want.y, got.y);
                    report_field("kept_ms", want.ms, got.ms);
                    report_field("point_index", want.idx, got.idx);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CAPTURE_MODE:
                    begin
                        // A new mode starts a fresh capture.
                        pm_mode  = mode_t'(cfg_data[1:0]);
                        pm_count = '0;
                    end
                    REG_WINDOW_MS:    pm_window     = cfg_data;
                    REG_MIN_DISTANCE: pm_min_dist   = cfg_data[16:0];
                    REG_MAX_POINTS:   pm_max_points = cfg_data[15:0];
                    REG_MIN_GAP_MS:   pm_min_gap    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                taken.op  = s_tuser;
                taken.x   = s_tdata[15:0];
                taken.y   = s_tdata[31:16];
                taken.btn = s_tdata[32];
                taken.ms  = s_tdata[64:33];
                expected_points.insert(expected_points.size(), qualify_sample(taken));
            end
        end
    end

    // Sender. A word stays on the bus until it is taken; only then may the next
    // one go up, or the bus go idle.
    always @(negedge clk)
    begin
        ptr_word_t w;
        if (!s_tvalid || in_fire)
        begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                w = sample_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.op;
                s_tdata  <= {7'b0, w.ms, w.btn, w.y, w.x};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver. A requested hold-off is counted down here and keeps tready low
    // the whole time; otherwise tready drops at the current idle rate.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: the run is hung if no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("pointer_sample_qualifier: mismatch");
            $finish;
        end
    end

    task automatic push_word(input logic op, input logic [15:0] x, input logic [15:0] y,
                             input logic btn, input logic [31:0] ms);
        ptr_word_t w;
        w.op  = op;
        w.x   = x;
        w.y   = y;
        w.btn = btn;
        w.ms  = ms;
        sample_queue.insert(sample_queue.size(), w);
    endtask

    // Waits until every queued word has been taken and every result has come
    // back, then lets the two pipeline stages settle before registers change.
    task automatic drain();
        while (sample_queue.size() != 0 || s_tvalid || expected_points.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    // Loads a complete setting. The mode goes last because writing it clears the
    // captured points.
    task automatic apply_setting(input mode_t mode, input logic [31:0] window,
                                 input logic [16:0] min_dist, input logic [15:0] max_points,
                                 input logic [31:0] min_gap);
        drain();
        write_reg(REG_WINDOW_MS, window);
        write_reg(REG_MIN_DISTANCE, {15'b0, min_dist});
        write_reg(REG_MAX_POINTS, {16'b0, max_points});
        write_reg(REG_MIN_GAP_MS, min_gap);
        write_reg(REG_CAPTURE_MODE, {30'b0, mode});
    endtask

    // Random traffic for the current setting. Most words follow a pointer that
    // moves and ticks in steps scaled to the active threshold, so that keeps and
    // drops alternate; the rest are clears and words with random content.
    task automatic random_traffic(input int n);
        int          i;
        int          roll;
        int          span;
        int          dx;
        int          dy;
        logic [31:0] stride;
        for (i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
                push_word(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), $urandom);
            else if (roll < 14)
            begin
                gen_ms = $urandom;
                gen_x  = 16'($urandom);
                gen_y  = 16'($urandom);
                push_word(OP_SAMPLE, gen_x, gen_y, 1'($urandom), gen_ms);
            end
            else
            begin
                case (pm_mode)
                    MODE_TIME:
                        stride = (pm_window > 100000) ? $urandom_range(0, 5000)
                                                      : $urandom_range(0, pm_window / 6 + 1);
                    MODE_POINTS:
                        stride = (pm_min_gap > 100000) ? $urandom
                                                       : $urandom_range(0, 2 * pm_min_gap + 2);
                    default:
                        stride = $urandom_range(0, 50);
                endcase
                span = 300;
                if (pm_mode == MODE_DIST)
                    span = (pm_min_dist > 60000) ? 30000 : int'(pm_min_dist) / 2 + 2;
                dx = $urandom_range(0, 2 * span) - span;
                dy = $urandom_range(0, 2 * span) - span;
                gen_ms = gen_ms + stride;
                gen_x  = gen_x + 16'(dx);
                gen_y  = gen_y + 16'(dy);
                push_word(OP_SAMPLE, gen_x, gen_y,
                          (pm_mode == MODE_POINTS) ? ($urandom_range(0, 99) < 85)
                                                   : 1'($urandom), gen_ms);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 50;

        // Directed words, first under the reset setting: point mode, gap 100, at
        // most 20 points. A released button keeps nothing, even as the first point.
        push_word(OP_SAMPLE, 16'h0000, 16'h0000, 1'b0, 32'd0);
        push_word(OP_SAMPLE, 16'h8000, 16'h7fff, 1'b1, 32'd1000);
        // Exactly the gap is not enough; one more millisecond is.
        push_word(OP_SAMPLE, 16'h0001, 16'h0001, 1'b1, 32'd1100);
        push_word(OP_SAMPLE, 16'h7fff, 16'h8000, 1'b1, 32'd1101);
        push_word(OP_CLEAR, 16'hffff, 16'hffff, 1'b1, 32'hffff_ffff);
        // The gap is measured across the wrap of the stamp.
        push_word(OP_SAMPLE, 16'hffff, 16'h0000, 1'b1, 32'hffff_fff0);
        push_word(OP_SAMPLE, 16'h0000, 16'hffff, 1'b1, 32'h0000_0060);
        push_word(OP_SAMPLE, 16'h1234, 16'h4321, 1'b0, 32'hffff_ffff);

        // Writes past the last register must change nothing.
        drain();
        write_reg(REG_SPARE_LO, 32'hffff_ffff);
        write_reg(REG_SPARE_HI, 32'h0000_0003);
        push_word(OP_SAMPLE, 16'h0100, 16'h0100, 1'b1, 32'h0000_1000);

        // Time mode with a 50 ms window, again across the wrap: 49 ms is inside,
        // 50 ms is not.
        apply_setting(MODE_TIME, 32'd50, 17'd20, 16'd20, 32'd100);
        push_word(OP_SAMPLE, 16'h0005, 16'hfffb, 1'b0, 32'hffff_ffe0);
        push_word(OP_SAMPLE, 16'h0006, 16'hfffa, 1'b1, 32'h0000_0011);
        push_word(OP_SAMPLE, 16'h0007, 16'hfff9, 1'b0, 32'h0000_0012);
        push_word(OP_CLEAR, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000);
        push_word(OP_SAMPLE, 16'h0008, 16'hfff8, 1'b0, 32'h0000_0005);

        // Distance mode: a Manhattan distance of exactly the threshold is dropped.
        apply_setting(MODE_DIST, 32'd50, 17'd100, 16'd20, 32'd100);
        push_word(OP_SAMPLE, 16'h0000, 16'h0000, 1'b0, 32'h0000_0100);
        push_word(OP_SAMPLE, 16'd50, 16'd50, 1'b1, 32'h0000_0101);
        push_word(OP_SAMPLE, 16'd51, -16'sd50, 1'b0, 32'h0000_0102);
        push_word(OP_SAMPLE, 16'h8000, 16'h8000, 1'b1, 32'h0000_0103);

        // Mode three keeps nothing, not even the first sample.
        apply_setting(MODE_NONE, 32'd50, 17'd100, 16'd20, 32'd100);
        push_word(OP_SAMPLE, 16'h0010, 16'h0010, 1'b1, 32'h0000_0200);
        push_word(OP_CLEAR, 16'h0000, 16'h0000, 1'b1, 32'h0000_0201);
        push_word(OP_SAMPLE, 16'h0020, 16'h0020, 1'b1, 32'h0000_0202);

        // Random traffic, first phase: sender idles lightly, receiver heavily.
        apply_setting(MODE_TIME, 32'd300, 17'd20, 16'd20, 32'd100);
        random_traffic(70);
        apply_setting(MODE_DIST, 32'd300, 17'd40, 16'd20, 32'd100);
        // The receiver holds off while words keep coming, so both pipeline
        // registers fill and the input has to stall.
        @(posedge clk);
        hold_left = 80;
        random_traffic(70);
        apply_setting(MODE_POINTS, 32'd300, 17'd40, 16'd5, 32'd30);
        random_traffic(60);

        // Second phase: the idle rates swap.
        drain();
        send_idle_pct = 50;
        recv_idle_pct = 22;
        apply_setting(MODE_POINTS, 32'd300, 17'd40, 16'hffff, 32'd0);
        random_traffic(60);
        apply_setting(MODE_TIME, 32'hffff_ffff, 17'd40, 16'hffff, 32'd0);
        random_traffic(40);
        apply_setting(MODE_TIME, 32'd0, 17'd40, 16'hffff, 32'd0);
        random_traffic(20);
        apply_setting(MODE_DIST, 32'd0, 17'd0, 16'hffff, 32'd0);
        random_traffic(50);
        apply_setting(MODE_DIST, 32'd0, 17'h1ffff, 16'hffff, 32'd0);
        random_traffic(20);
        apply_setting(MODE_POINTS, 32'd0, 17'h1ffff, 16'd0, 32'hffff_ffff);
        random_traffic(20);
        apply_setting(MODE_NONE, 32'd0, 17'h1ffff, 16'd0, 32'hffff_ffff);
        random_traffic(10);

        // Third phase: no idling on either side.
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(MODE_TIME, 32'd1000, 17'd20, 16'd20, 32'd100);
        random_traffic(30);
        // Changing the window alone must keep the points captured so far.
        drain();
        write_reg(REG_WINDOW_MS, 32'd5000);
        random_traffic(30);
        apply_setting(MODE_POINTS, 32'd5000, 17'd20, 16'd20, 32'd100);
        random_traffic(60);

        // With the widest window every sample is kept; a clear then starts the
        // index again from zero.
        apply_setting(MODE_TIME, 32'hffff_ffff, 17'd20, 16'd20, 32'd100);
        push_word(OP_SAMPLE, 16'h0003, 16'h0004, 1'b1, 32'h0000_3fff);
        push_word(OP_CLEAR, 16'h0000, 16'h0000, 1'b0, 32'h0000_4000);
        push_word(OP_SAMPLE, 16'h0001, 16'h0002, 1'b0, 32'h0000_4001);

        drain();
        if (mismatches == 0)
            $display("pointer_sample_qualifier: match");
        else
            $display("pointer_sample_qualifier: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
